// File: rtl/multiplexed_seven_segment_driver_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the seven-segment display driver
// Shared property wrappers so that every check uses the same clocking.
// ---------------------------------------------------------------------------
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH

// A property checked on every rising edge, with reset held off the check.
`define MSSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// A property that must also hold while reset is asserted.
`define MSSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/mssd_pkg.sv
// ---------------------------------------------------------------------------
// Seven-segment driver package
// Command codes, decimal split constants and the segment decoder.
// ---------------------------------------------------------------------------
package mssd_pkg;

  // Commands carried in the selector of an input word.
  localparam logic [1:0] CmdTick  = 2'd0;
  localparam logic [1:0] CmdScore = 2'd1;
  localparam logic [1:0] CmdLamp  = 2'd2;

  // Number of digit positions held by the display store.
  localparam int unsigned StoreDepth = 4;
  localparam int unsigned NumDigitsDefault = 4;

  // Scores saturate at four decimal digits.
  localparam logic [13:0] ScoreCap = 14'd9999;

  // Reciprocal constants for the decimal split.
  // 8389 / 2^23 gives the thousands for values up to 9999.
  localparam logic [13:0] ThouRecip = 14'd8389;
  localparam int unsigned ThouShift = 23;
  // 656 / 2^16 gives the hundreds for values up to 999.
  localparam logic [9:0]  HundRecip = 10'd656;
  localparam int unsigned HundShift = 16;
  // 205 / 2^11 gives the tens quotient for values up to 999.
  localparam logic [7:0]  TenRecip  = 8'd205;
  localparam int unsigned TenShift  = 11;

  // Pins at reset: all segments dark.
  localparam logic [6:0] SegBlank = 7'h7F;

  // Active-low segment pattern, segment a in bit 0 and g in bit 6.
  function automatic logic [6:0] seg_pattern(logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h40;
      4'd1:    pat = 7'h79;
      4'd2:    pat = 7'h24;
      4'd3:    pat = 7'h30;
      4'd4:    pat = 7'h19;
      4'd5:    pat = 7'h12;
      4'd6:    pat = 7'h02;
      4'd7:    pat = 7'h78;
      4'd8:    pat = 7'h00;
      4'd9:    pat = 7'h10;
      default: pat = SegBlank;
    endcase
    return pat;
  endfunction

endpackage

// File: rtl/multiplexed_seven_segment_driver.sv
// ---------------------------------------------------------------------------
// Multiplexed seven-segment display driver
// Four-digit scanned display with three status lamps.
// ---------------------------------------------------------------------------
//  Channel   Direction  Payload                                   Handshake
//  s_axis    in         tuser: cmd; tdata: score_value, lamp      tvalid/tready
//  m_axis    out        tdata: segments_n, digit_on, lamps        tvalid/tready
//
//  Each word passes through the input register, where the thousands digit is
//  split off, then through the update stage that writes the display latches.
//  One word is accepted every cycle while results are taken.
//  Reset is asynchronous and active low; it blanks the segments, clears
//  the digit enables, lamps, scan position and stored digits.
//  A stalled result holds the update stage, and the input register fills
//  before s_axis_tready falls.
// ---------------------------------------------------------------------------
module multiplexed_seven_segment_driver
  import mssd_pkg::*;
#(
  parameter int unsigned NUM_DIGITS = NumDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [1:0] cmd
  input  logic [1:0]  s_axis_tuser,
  // [15:0] score_value, [17:16] lamp_choice, [23:18] zero
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] segments_n, [10:7] digit_on, [13:11] lamps, [15:14] zero
  output logic [15:0] m_axis_tdata
);

  // Scan length is clamped to the stored digit count.
  localparam int unsigned ScanLen =
    (NUM_DIGITS < 1) ? 1 : ((NUM_DIGITS > StoreDepth) ? StoreDepth : NUM_DIGITS);
  localparam logic [1:0] ScanLast = 2'(ScanLen - 1);

  // Input stage: saturate the score and split off the thousands digit.
  logic [15:0] in_score;
  logic [13:0] in_sat;
  logic [27:0] thou_prod;
  logic [3:0]  in_thou;
  logic [13:0] in_rem_full;

  assign in_score    = s_axis_tdata[15:0];
  assign in_sat      = (in_score > 16'(ScoreCap)) ? ScoreCap : in_score[13:0];
  assign thou_prod   = 28'(in_sat) * 28'(ThouRecip);
  assign in_thou     = thou_prod[ThouShift +: 4];
  assign in_rem_full = in_sat - 14'(14'(in_thou) * 14'd1000);

  logic       s1_valid_q;
  logic [1:0] s1_cmd_q;
  logic [3:0] s1_thou_q;
  logic [9:0] s1_rem_q;
  logic [1:0] s1_lamp_q;
  logic       upd_fire;
  logic       in_fire;
  logic       tick_fire;

  assign upd_fire      = s1_valid_q && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || upd_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign tick_fire     = upd_fire && (s1_cmd_q == CmdTick);

  // Input register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= s_axis_tvalid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_cmd_q  <= s_axis_tuser;
      s1_thou_q <= in_thou;
      s1_rem_q  <= in_rem_full[9:0];
      s1_lamp_q <= s_axis_tdata[17:16];
    end
  end

  // Remaining digits from the sub-thousand remainder.
  logic [19:0] hund_prod;
  logic [17:0] ten_prod;
  logic [3:0]  rem_hund;
  logic [6:0]  rem_q10;
  logic [6:0]  tens_full;
  logic [9:0]  ones_full;

  assign hund_prod = 20'(s1_rem_q) * 20'(HundRecip);
  assign ten_prod  = 18'(s1_rem_q) * 18'(TenRecip);
  assign rem_hund  = hund_prod[HundShift +: 4];
  assign rem_q10   = ten_prod[TenShift +: 7];
  assign tens_full = rem_q10 - 7'(7'(rem_hund) * 7'd10);
  assign ones_full = s1_rem_q - 10'(10'(rem_q10) * 10'd10);

  // Display state: digit store, scan position and the pin latches.
  logic [3:0] digit_q [StoreDepth];
  logic [1:0] scan_q;
  logic [6:0] seg_q;
  logic [3:0] dig_q;
  logic [2:0] lamp_q;
  logic       out_valid_q;
  logic [1:0] scan_d;

  assign scan_d = (scan_q == ScanLast) ? 2'd0 : scan_q + 2'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < StoreDepth; i++) begin
        digit_q[i] <= 4'd0;
      end
      scan_q <= 2'd0;
      seg_q  <= SegBlank;
      dig_q  <= 4'd0;
      lamp_q <= 3'd0;
    end else if (upd_fire) begin
      case (s1_cmd_q)
        CmdTick: begin
          seg_q  <= seg_pattern(digit_q[scan_q]);
          dig_q  <= 4'd1 << scan_q;
          scan_q <= scan_d;
        end
        CmdScore: begin
          digit_q[0] <= s1_thou_q;
          digit_q[1] <= rem_hund;
          digit_q[2] <= tens_full[3:0];
          digit_q[3] <= ones_full[3:0];
        end
        CmdLamp: begin
          if (s1_lamp_q == 2'd0) begin
            lamp_q <= 3'd0;
          end else begin
            lamp_q <= 3'd1 << (s1_lamp_q - 2'd1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Result word valid: the latches are the result payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (upd_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, lamp_q, dig_q, seg_q};

  // Checks on the display latches and scan position.
`include "multiplexed_seven_segment_driver_assert.svh"

  `MSSD_ASSERT(a_dig_onehot, $onehot0(dig_q), "digit enables not one-hot")
  `MSSD_ASSERT(a_lamp_onehot, $onehot0(lamp_q), "more than one lamp lit")
  `MSSD_ASSERT(a_dark_blank, (dig_q != 4'd0) || (seg_q == SegBlank), "segments lit with no digit")
  `MSSD_ASSERT(a_scan_range, scan_q <= ScanLast, "scan position beyond scan length")
  `MSSD_ASSERT(a_tick_enable, tick_fire |=> dig_q == (4'd1 << $past(scan_q)), "wrong digit enabled")

endmodule

// File: sim/multiplexed_seven_segment_driver_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the multiplexed seven-segment display driver
// Sends tick, score, lamp and unused command words through the input stream.
// A predictor of the display latches works out the pins for each accepted
// word, and every result word is checked field by field against them.
// ---------------------------------------------------------------------------
module multiplexed_seven_segment_driver_tb;
  import mssd_pkg::*;

  // Command code that the block must ignore.
  localparam logic [1:0] CmdUnused = 2'd3;

  localparam int unsigned NumDigits  = 4;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  // Pins of the display as seen in one result word.
  typedef struct packed {
    logic [2:0] lamps;
    logic [3:0] digit_on;
    logic [6:0] segments_n;
  } display_pins_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = CmdTick;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;

  // Predicted display state.
  logic [3:0] held_digits [StoreDepth];
  int unsigned scan_pos;
  logic [6:0] seg_hold;
  logic [3:0] digit_hold;
  logic [2:0] lamp_hold;

  // Pins expected from the words accepted so far, oldest first.
  display_pins_t pins_expected [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned tick_count = 0;
  int unsigned score_count = 0;
  int unsigned lamp_count = 0;

  multiplexed_seven_segment_driver #(
    .NUM_DIGITS (NumDigits)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Clock with a 4 ns period.
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Common-anode glyph codes; the top bit is the unused decimal point.
  function automatic logic [6:0] glyph_for(logic [3:0] digit);
    logic [7:0] code;
    case (digit)
      4'd0:    code = 8'hC0;
      4'd1:    code = 8'hF9;
      4'd2:    code = 8'hA4;
      4'd3:    code = 8'hB0;
      4'd4:    code = 8'h99;
      4'd5:    code = 8'h92;
      4'd6:    code = 8'h82;
      4'd7:    code = 8'hF8;
      4'd8:    code = 8'h80;
      4'd9:    code = 8'h90;
      default: code = 8'hFF;
    endcase
    return code[6:0];
  endfunction

  function automatic void clear_display();
    for (int i = 0; i < StoreDepth; i++) held_digits[i] = 4'd0;
    scan_pos   = 0;
    seg_hold   = SegBlank;
    digit_hold = 4'd0;
    lamp_hold  = 3'd0;
  endfunction

  // Applies one word to the predicted state and returns the pins after it.
  function automatic display_pins_t update_display(logic [1:0] cmd_code,
                                                   logic [15:0] score,
                                                   logic [1:0] lamp);
    int unsigned capped;
    int unsigned scan_len;
    display_pins_t pins;
    scan_len = (NumDigits < 1) ? 1 : ((NumDigits > StoreDepth) ? StoreDepth : NumDigits);
    case (cmd_code)
      CmdTick: begin
        seg_hold   = glyph_for(held_digits[scan_pos]);
        digit_hold = 4'(1 << scan_pos);
        scan_pos   = (scan_pos + 1 >= scan_len) ? 0 : scan_pos + 1;
      end
      CmdScore: begin
        capped = (score > ScoreCap) ? ScoreCap : score;
        held_digits[0] = 4'((capped / 1000) % 10);
        held_digits[1] = 4'((capped / 100) % 10);
        held_digits[2] = 4'((capped / 10) % 10);
        held_digits[3] = 4'(capped % 10);
      end
      CmdLamp: begin
        lamp_hold = (lamp == 2'd0) ? 3'd0 : 3'(1 << (lamp - 1));
      end
      default: ;
    endcase
    pins.segments_n = seg_hold;
    pins.digit_on   = digit_hold;
    pins.lamps      = lamp_hold;
    return pins;
  endfunction

  // Offers one word, with random idle cycles first, and records its pins.
  task automatic send_word(logic [1:0] cmd_code, logic [15:0] score, logic [1:0] lamp);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd_code;
    s_axis_tdata  <= {6'd0, lamp, score};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pins_expected.push_back(update_display(cmd_code, score, lamp));
    words_sent++;
    case (cmd_code)
      CmdTick:  tick_count++;
      CmdScore: score_count++;
      CmdLamp:  lamp_count++;
      default: ;
    endcase
  endtask

  // Result checker and random receiver stalls.
  always @(posedge clk_i) begin
    display_pins_t got;
    display_pins_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[13:0];
      if (pins_expected.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result word: seg %h dig %b lamps %b",
                   got.segments_n, got.digit_on, got.lamps);
      end else begin
        want = pins_expected.pop_front();
        words_checked++;
        if (got.segments_n !== want.segments_n || got.digit_on !== want.digit_on ||
            got.lamps !== want.lamps) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch on word %0d: seg %h/%h dig %b/%b lamps %b/%b (exp/act)",
                     words_checked, want.segments_n, got.segments_n,
                     want.digit_on, got.digit_on, want.lamps, got.lamps);
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // The latches read blank before any tick, and the stored digits read zero.
  task automatic test_reset_view();
    send_word(CmdUnused, 16'h0000, 2'd0);
    repeat (4) send_word(CmdTick, 16'h0000, 2'd0);
  endtask

  // Saturation above 9999 and the smallest score.
  task automatic test_score_extremes();
    send_word(CmdScore, 16'hFFFF, 2'd3);
    repeat (4) send_word(CmdTick, 16'hFFFF, 2'd3);
    send_word(CmdScore, 16'd10000, 2'd0);
    send_word(CmdTick, 16'd0, 2'd0);
    send_word(CmdScore, 16'd0, 2'd0);
    send_word(CmdTick, 16'd0, 2'd0);
  endtask

  // Every lamp choice, with stray score bits on the bus.
  task automatic test_lamps();
    for (int i = 1; i < 4; i++) send_word(CmdLamp, 16'hA5A5, 2'(i));
    send_word(CmdLamp, 16'h5A5A, 2'd0);
  endtask

  // The unused command must change nothing, whatever the fields hold.
  task automatic test_unused_command();
    send_word(CmdLamp, 16'd0, 2'd2);
    send_word(CmdUnused, 16'hFFFF, 2'd3);
    send_word(CmdTick, 16'd0, 2'd0);
  endtask

  // Random words, mostly ticks, under one idling setting.
  task automatic test_random_traffic(int unsigned n_words, int unsigned idle_pct,
                                     int unsigned stall_pct);
    int unsigned pick;
    logic [15:0] score;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_words; i++) begin
      case ($urandom_range(3))
        0:       score = 16'($urandom_range(65535));
        1:       score = 16'($urandom_range(9999));
        2:       score = 16'($urandom_range(10010, 9990));
        default: score = 16'($urandom_range(99));
      endcase
      pick = $urandom_range(99);
      if (pick < 55)
        send_word(CmdTick, score, 2'($urandom_range(3)));
      else if (pick < 75)
        send_word(CmdScore, score, 2'($urandom_range(3)));
      else if (pick < 95)
        send_word(CmdLamp, score, 2'($urandom_range(3)));
      else
        send_word(CmdUnused, score, 2'($urandom_range(3)));
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    clear_display();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_view();
    test_score_extremes();
    test_lamps();
    test_unused_command();
    test_random_traffic(120, 0, 0);
    test_random_traffic(120, 62, 0);
    test_random_traffic(120, 0, 62);
    test_random_traffic(120, 15, 15);

    // Let the pipeline drain before judging.
    while (pins_expected.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d words (%0d ticks, %0d score loads, %0d lamp commands).",
             words_sent, tick_count, score_count, lamp_count);
    $display("Checked %0d result words under four idling settings; %0d mismatches.",
             words_checked, mismatch_count);
    if (mismatch_count == 0 && pins_expected.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
